@@ design/cpi_pkg.sv @@
package cpi_pkg;

	typedef logic [1:0] meet_t;

	localparam meet_t MEET_NONE    = 2'd0;
	localparam meet_t MEET_TANGENT = 2'd1;
	localparam meet_t MEET_TWO     = 2'd2;

	localparam int PT_W      = 18;
	localparam int QUO_BITS  = 18;
	localparam logic [15:0] TOL_RESET = 16'd256;

	// per-item data that rides alongside the square-root pipeline
	typedef struct packed {
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic        [15:0] sum;
		logic        [14:0] dif;
		logic        [33:0] bigd;
		logic signed [31:0] tnx;
		logic signed [31:0] tny;
		logic               pos;
		logic signed [53:0] tx;
		logic signed [53:0] ty;
	} cpi_side_t;

endpackage

@@ design/circle_pair_intersection.sv @@
// Circle pair intersection: one circle pair is taken per clock cycle, busy is never raised and
// the block never stalls. Each pair gives one result, strobed on done for a single cycle; the
// receiver must take it then. The pipeline holds two 32 + FRACTION_BITS stage square-root
// lanes (centre distance and chord term) and the 18-stage restoring divider that yields the
// point coordinates. The tangent tolerance is written through cfg_valid/cfg_data and must
// only change while no pair is in flight.
module circle_pair_intersection #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [15:0]        first_center_x,
	input  logic signed [15:0]        first_center_y,
	input  logic        [14:0]        first_radius,
	input  logic signed [15:0]        second_center_x,
	input  logic signed [15:0]        second_center_y,
	input  logic        [14:0]        second_radius,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic        [15:0]        cfg_data,
	output logic                      done,
	output cpi_pkg::meet_t            meet_status,
	output logic signed [17:0]        point_one_x,
	output logic signed [17:0]        point_one_y,
	output logic signed [17:0]        point_two_x,
	output logic signed [17:0]        point_two_y
);
	import cpi_pkg::*;

	localparam int F   = FRACTION_BITS;
	localparam int RW  = 32 + F;
	localparam int EW  = RW + 1;
	localparam int OW  = RW + 18;
	localparam int TW  = 54;
	localparam int NW  = 56 + F;
	localparam int DW  = 35 + F;
	localparam int QB  = QUO_BITS;
	localparam int LAT = 10 + RW + QB;

	logic [15:0] tol_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// front end
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [15:0] x1_s1, y1_s1, x2_s1, y2_s1;
	logic        [14:0] r1_s1, r2_s1;

	logic signed [15:0] x1_s2, y1_s2;
	logic signed [16:0] dx_s2, dy_s2;
	logic        [15:0] sum_s2;
	logic        [14:0] dif_s2, r1_s2, r2_s2;
	logic signed [15:0] x2_s2, y2_s2;

	logic signed [15:0] x1_s3, y1_s3;
	logic signed [16:0] dx_s3, dy_s3;
	logic        [15:0] sum_s3;
	logic        [14:0] dif_s3;
	logic        [31:0] dxx_s3, dyy_s3, sumsq_s3;
	logic        [29:0] r1sq_s3, r2sq_s3, difsq_s3;
	logic signed [31:0] ax_s3, bx_s3, ay_s3, by_s3;

	logic signed [15:0] x1_s4, y1_s4;
	logic signed [16:0] dx_s4, dy_s4;
	logic        [15:0] sum_s4;
	logic        [14:0] dif_s4;
	logic        [33:0] bigd_s4;
	logic        [31:0] sumsq_s4;
	logic        [29:0] difsq_s4;
	logic signed [31:0] tnx_s4, tny_s4;
	logic signed [30:0] rr_s4;

	logic signed [15:0] x1_s5, y1_s5;
	logic signed [16:0] dx_s5, dy_s5;
	logic        [15:0] sum_s5;
	logic        [14:0] dif_s5;
	logic        [33:0] bigd_s5;
	logic signed [31:0] tnx_s5, tny_s5;
	logic        [31:0] f1_s5, f2_s5;
	logic signed [35:0] n_s5;
	logic               pos_s5;

	cpi_side_t          sd_s6;
	logic        [63:0] k_s6;
	logic signed [51:0] tax_s6, tay_s6;
	logic signed [52:0] nxp_s6, nyp_s6;

	logic signed [33:0] dxx_w, dyy_w;
	logic signed [31:0] ax_w, bx_w, ay_w, by_w;
	logic        [29:0] r1sq_w, r2sq_w, difsq_w;
	logic        [31:0] sumsq_w;
	logic signed [51:0] tax_w, tay_w;
	logic signed [52:0] nxp_w, nyp_w;
	logic        [63:0] k_w;

	assign dxx_w   = dx_s2 * dx_s2;
	assign dyy_w   = dy_s2 * dy_s2;
	assign r1sq_w  = r1_s2 * r1_s2;
	assign r2sq_w  = r2_s2 * r2_s2;
	assign difsq_w = dif_s2 * dif_s2;
	assign sumsq_w = sum_s2 * sum_s2;
	assign ax_w    = x1_s2 * $signed({1'b0, r2_s2});
	assign bx_w    = x2_s2 * $signed({1'b0, r1_s2});
	assign ay_w    = y1_s2 * $signed({1'b0, r2_s2});
	assign by_w    = y2_s2 * $signed({1'b0, r1_s2});
	assign k_w     = f1_s5 * f2_s5;
	assign tax_w   = $signed({1'b0, bigd_s5, 1'b0}) * x1_s5;
	assign tay_w   = $signed({1'b0, bigd_s5, 1'b0}) * y1_s5;
	assign nxp_w   = n_s5 * dx_s5;
	assign nyp_w   = n_s5 * dy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		x1_s1 <= first_center_x;
		y1_s1 <= first_center_y;
		r1_s1 <= first_radius;
		x2_s1 <= second_center_x;
		y2_s1 <= second_center_y;
		r2_s1 <= second_radius;

		x1_s2  <= x1_s1;
		y1_s2  <= y1_s1;
		x2_s2  <= x2_s1;
		y2_s2  <= y2_s1;
		r1_s2  <= r1_s1;
		r2_s2  <= r2_s1;
		dx_s2  <= {x2_s1[15], x2_s1} - {x1_s1[15], x1_s1};
		dy_s2  <= {y2_s1[15], y2_s1} - {y1_s1[15], y1_s1};
		sum_s2 <= {1'b0, r1_s1} + {1'b0, r2_s1};
		dif_s2 <= (r1_s1 > r2_s1) ? r1_s1 - r2_s1 : r2_s1 - r1_s1;

		x1_s3    <= x1_s2;
		y1_s3    <= y1_s2;
		dx_s3    <= dx_s2;
		dy_s3    <= dy_s2;
		sum_s3   <= sum_s2;
		dif_s3   <= dif_s2;
		dxx_s3   <= dxx_w[31:0];
		dyy_s3   <= dyy_w[31:0];
		sumsq_s3 <= sumsq_w;
		r1sq_s3  <= r1sq_w;
		r2sq_s3  <= r2sq_w;
		difsq_s3 <= difsq_w;
		ax_s3    <= ax_w;
		bx_s3    <= bx_w;
		ay_s3    <= ay_w;
		by_s3    <= by_w;

		x1_s4    <= x1_s3;
		y1_s4    <= y1_s3;
		dx_s4    <= dx_s3;
		dy_s4    <= dy_s3;
		sum_s4   <= sum_s3;
		dif_s4   <= dif_s3;
		sumsq_s4 <= sumsq_s3;
		difsq_s4 <= difsq_s3;
		bigd_s4  <= {2'b00, dxx_s3} + {2'b00, dyy_s3};
		tnx_s4   <= ax_s3 + bx_s3;
		tny_s4   <= ay_s3 + by_s3;
		rr_s4    <= $signed({1'b0, r1sq_s3}) - $signed({1'b0, r2sq_s3});

		x1_s5   <= x1_s4;
		y1_s5   <= y1_s4;
		dx_s5   <= dx_s4;
		dy_s5   <= dy_s4;
		sum_s5  <= sum_s4;
		dif_s5  <= dif_s4;
		bigd_s5 <= bigd_s4;
		tnx_s5  <= tnx_s4;
		tny_s5  <= tny_s4;
		f1_s5   <= sumsq_s4 - bigd_s4[31:0];
		f2_s5   <= bigd_s4[31:0] - {2'b00, difsq_s4};
		n_s5    <= {{5{rr_s4[30]}}, rr_s4} + $signed({2'b00, bigd_s4});
		pos_s5  <= (bigd_s4 != 34'd0) && (bigd_s4 >= {4'b0000, difsq_s4});

		k_s6       <= k_w;
		tax_s6     <= tax_w;
		tay_s6     <= tay_w;
		nxp_s6     <= nxp_w;
		nyp_s6     <= nyp_w;
		sd_s6.x1   <= x1_s5;
		sd_s6.y1   <= y1_s5;
		sd_s6.dx   <= dx_s5;
		sd_s6.dy   <= dy_s5;
		sd_s6.sum  <= sum_s5;
		sd_s6.dif  <= dif_s5;
		sd_s6.bigd <= bigd_s5;
		sd_s6.tnx  <= tnx_s5;
		sd_s6.tny  <= tny_s5;
		sd_s6.pos  <= pos_s5;
		sd_s6.tx   <= '0;
		sd_s6.ty   <= '0;
	end

	// square roots, one root bit per stage: lane 0 centre distance, lane 1 chord term
	cpi_side_t          sd_in;
	cpi_side_t          side_s   [RW];
	logic               sq_v_s   [RW];
	logic [RW+1:0]      sq_rem_s [2][RW];
	logic [RW-1:0]      sq_root_s[2][RW];
	logic [2*RW-1:0]    sq_rad_s [2][RW];

	always_comb begin
		sd_in    = sd_s6;
		sd_in.tx = {{2{tax_s6[51]}}, tax_s6} + {nxp_s6[52], nxp_s6};
		sd_in.ty = {{2{tay_s6[51]}}, tay_s6} + {nyp_s6[52], nyp_s6};
	end

	for (genvar k = 0; k < RW; k++) begin : g_sq
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_v_s[k] <= 1'b0;
				end else begin
					sq_v_s[k] <= v_s6;
				end
			end
			always_ff @(posedge clk) begin
				side_s[k] <= sd_in;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_v_s[k] <= 1'b0;
				end else begin
					sq_v_s[k] <= sq_v_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				side_s[k] <= side_s[k-1];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [RW+1:0]   rem_in;
			logic [RW-1:0]   root_in;
			logic [2*RW-1:0] rad_in;
			logic [RW+2:0]   rem_x;
			logic [RW+2:0]   rem_nx;
			logic [RW+2:0]   trial;
			logic            ge;

			if (k == 0) begin : g_src
				assign rem_in  = '0;
				assign root_in = '0;
				if (l == 0) begin : g_d
					assign rad_in = {{(2*RW-34-2*F){1'b0}}, sd_s6.bigd, {(2*F){1'b0}}};
				end else begin : g_k
					assign rad_in = {k_s6, {(2*F){1'b0}}};
				end
			end else begin : g_prev
				assign rem_in  = sq_rem_s[l][k-1];
				assign root_in = sq_root_s[l][k-1];
				assign rad_in  = sq_rad_s[l][k-1];
			end

			// remainder never exceeds twice the root, so its top bit stays clear
			assign rem_x  = {rem_in[RW:0], rad_in[2*RW-1 -: 2]};
			assign trial  = {1'b0, root_in, 2'b01};
			assign ge     = rem_x >= trial;
			assign rem_nx = ge ? (rem_x - trial) : rem_x;

			always_ff @(posedge clk) begin
				sq_rem_s[l][k]  <= rem_nx[RW+1:0];
				sq_root_s[l][k] <= {root_in[RW-2:0], ge};
				sq_rad_s[l][k]  <= {rad_in[2*RW-3:0], 2'b00};
			end
		end
	end

	// decision and chord products
	cpi_side_t          sdp;
	logic [RW-1:0]      d_f, s_f;
	logic [EW-1:0]      sumf, diff, tolf, e1, e2;
	logic               tan_w, two_w;
	logic signed [OW-1:0] ox_w, oy_w;

	assign sdp  = side_s[RW-1];
	assign d_f  = sq_root_s[0][RW-1];
	assign s_f  = sq_root_s[1][RW-1];
	assign sumf = {{(EW-16-F){1'b0}}, sdp.sum, {F{1'b0}}};
	assign diff = {{(EW-15-F){1'b0}}, sdp.dif, {F{1'b0}}};
	assign tolf = {{(EW-8-F){1'b0}}, tol_q, {(F-8){1'b0}}};
	assign e1   = ({1'b0, d_f} >= sumf) ? ({1'b0, d_f} - sumf) : (sumf - {1'b0, d_f});
	assign e2   = ({1'b0, d_f} >= diff) ? ({1'b0, d_f} - diff) : (diff - {1'b0, d_f});
	assign tan_w = (e1 < tolf) || (e2 < tolf);
	assign two_w = !tan_w && ({1'b0, d_f} < sumf) && sdp.pos;
	assign ox_w  = $signed({1'b0, s_f}) * sdp.dy;
	assign oy_w  = $signed({1'b0, s_f}) * sdp.dx;

	logic                 v_sp;
	meet_t                st_sp;
	cpi_side_t            sd_sp;
	logic signed [OW-1:0] ox_sp, oy_sp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sp <= 1'b0;
		end else begin
			v_sp <= sq_v_s[RW-1];
		end
	end

	always_ff @(posedge clk) begin
		sd_sp <= sdp;
		ox_sp <= ox_w;
		oy_sp <= oy_w;
		if (tan_w) begin
			st_sp <= MEET_TANGENT;
		end else if (two_w) begin
			st_sp <= MEET_TWO;
		end else begin
			st_sp <= MEET_NONE;
		end
	end

	// numerators and divisor
	logic signed [NW-1:0] bx_n, by_n, ox_n, oy_n, tnx_n, tny_n;
	logic signed [NW-1:0] n1x_w, n1y_w, n2x_w, n2y_w;
	logic        [DW-1:0] den_w;

	assign bx_n  = {{(NW-TW-F){sd_sp.tx[TW-1]}}, sd_sp.tx, {F{1'b0}}};
	assign by_n  = {{(NW-TW-F){sd_sp.ty[TW-1]}}, sd_sp.ty, {F{1'b0}}};
	assign ox_n  = {{(NW-OW){ox_sp[OW-1]}}, ox_sp};
	assign oy_n  = {{(NW-OW){oy_sp[OW-1]}}, oy_sp};

	always_comb begin
		if (sd_sp.sum == 16'd0) begin
			tnx_n = {{(NW-16){sd_sp.x1[15]}}, sd_sp.x1};
			tny_n = {{(NW-16){sd_sp.y1[15]}}, sd_sp.y1};
		end else begin
			tnx_n = {{(NW-32){sd_sp.tnx[31]}}, sd_sp.tnx};
			tny_n = {{(NW-32){sd_sp.tny[31]}}, sd_sp.tny};
		end
		if (st_sp == MEET_TWO) begin
			n1x_w = bx_n + ox_n;
			n1y_w = by_n - oy_n;
			den_w = {sd_sp.bigd, 1'b0, {F{1'b0}}};
		end else begin
			n1x_w = tnx_n;
			n1y_w = tny_n;
			if (sd_sp.sum == 16'd0) begin
				den_w = {{(DW-1){1'b0}}, 1'b1};
			end else begin
				den_w = {{(DW-16){1'b0}}, sd_sp.sum};
			end
		end
		n2x_w = bx_n - ox_n;
		n2y_w = by_n + oy_n;
	end

	logic                 v_sn;
	meet_t                st_sn;
	logic [DW-1:0]        den_sn;
	logic signed [NW-1:0] num_sn [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else begin
			v_sn <= v_sp;
		end
	end

	always_ff @(posedge clk) begin
		st_sn     <= st_sp;
		den_sn    <= den_w;
		num_sn[0] <= n1x_w;
		num_sn[1] <= n1y_w;
		num_sn[2] <= n2x_w;
		num_sn[3] <= n2y_w;
	end

	// sign and magnitude
	logic          v_sa;
	meet_t         st_sa;
	logic [DW-1:0] den_sa;
	logic [NW-1:0] mag_sa [4];
	logic          neg_sa [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
		end else begin
			v_sa <= v_sn;
		end
	end

	always_ff @(posedge clk) begin
		st_sa  <= st_sn;
		den_sa <= den_sn;
	end

	for (genvar l = 0; l < 4; l++) begin : g_abs
		always_ff @(posedge clk) begin
			neg_sa[l] <= num_sn[l][NW-1];
			mag_sa[l] <= num_sn[l][NW-1] ? (~num_sn[l] + 1'b1) : num_sn[l];
		end
	end

	// restoring divider, one quotient bit per stage
	logic          dv_v_s   [QB];
	meet_t         dv_st_s  [QB];
	logic [DW-1:0] dv_den_s [QB];
	logic [NW-1:0] dv_rem_s [4][QB];
	logic [QB-1:0] dv_quo_s [4][QB];
	logic          dv_neg_s [4][QB];

	for (genvar j = 0; j < QB; j++) begin : g_dv
		logic [DW-1:0] den_in;
		logic [NW-1:0] trial;

		if (j == 0) begin : g_first
			assign den_in = den_sa;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[j] <= 1'b0;
				end else begin
					dv_v_s[j] <= v_sa;
				end
			end
			always_ff @(posedge clk) begin
				dv_st_s[j] <= st_sa;
			end
		end else begin : g_next
			assign den_in = dv_den_s[j-1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[j] <= 1'b0;
				end else begin
					dv_v_s[j] <= dv_v_s[j-1];
				end
			end
			always_ff @(posedge clk) begin
				dv_st_s[j] <= dv_st_s[j-1];
			end
		end

		assign trial = {{(NW-DW){1'b0}}, den_in} << (QB - 1 - j);

		always_ff @(posedge clk) begin
			dv_den_s[j] <= den_in;
		end

		for (genvar l = 0; l < 4; l++) begin : g_lane
			logic [NW-1:0] rem_in;
			logic [QB-1:0] quo_in;
			logic          neg_in;
			logic          ge;

			if (j == 0) begin : g_src
				assign rem_in = mag_sa[l];
				assign quo_in = '0;
				assign neg_in = neg_sa[l];
			end else begin : g_prev
				assign rem_in = dv_rem_s[l][j-1];
				assign quo_in = dv_quo_s[l][j-1];
				assign neg_in = dv_neg_s[l][j-1];
			end

			assign ge = rem_in >= trial;

			always_ff @(posedge clk) begin
				dv_rem_s[l][j] <= ge ? (rem_in - trial) : rem_in;
				dv_quo_s[l][j] <= {quo_in[QB-2:0], ge};
				dv_neg_s[l][j] <= neg_in;
			end
		end
	end

	// output register
	logic          done_q;
	meet_t         st_q;
	logic [PT_W-1:0] pt_q [4];
	logic [PT_W-1:0] pt_w [4];
	logic            keep_w [4];

	assign keep_w[0] = dv_st_s[QB-1] != MEET_NONE;
	assign keep_w[1] = dv_st_s[QB-1] != MEET_NONE;
	assign keep_w[2] = dv_st_s[QB-1] == MEET_TWO;
	assign keep_w[3] = dv_st_s[QB-1] == MEET_TWO;

	for (genvar l = 0; l < 4; l++) begin : g_out
		assign pt_w[l] = dv_neg_s[l][QB-1] ? (~dv_quo_s[l][QB-1] + 1'b1) : dv_quo_s[l][QB-1];
		always_ff @(posedge clk) begin
			pt_q[l] <= keep_w[l] ? pt_w[l] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v_s[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		st_q <= dv_st_s[QB-1];
	end

	assign done        = done_q;
	assign meet_status = st_q;
	assign point_one_x = pt_q[0];
	assign point_one_y = pt_q[1];
	assign point_two_x = pt_q[2];
	assign point_two_y = pt_q[3];

	// checks
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted pair did not produce a result in time");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching accepted pair");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && meet_status == MEET_NONE) |-> (point_one_x == '0 && point_one_y == '0))
		else $error("first point not cleared for no meeting");

	a_two_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && meet_status != MEET_TWO) |-> (point_two_x == '0 && point_two_y == '0))
		else $error("second point not cleared");

endmodule

@@ tb/sv/tb_circle_pair_intersection.sv @@
module tb_circle_pair_intersection;
	timeunit 1ns;
	timeprecision 1ps;

	import cpi_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 59 + FB;

	typedef struct {
		meet_t             st;
		logic signed [17:0] p1x;
		logic signed [17:0] p1y;
		logic signed [17:0] p2x;
		logic signed [17:0] p2y;
	} meet_res_t;

	typedef struct {
		int    x1, y1, r1, x2, y2, r2;
		bit    typed;
		meet_t st;
		int    p1x, p1y;
	} pair_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [15:0] first_center_x, first_center_y, second_center_x, second_center_y;
	logic [14:0] first_radius, second_radius;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;
	logic done;
	meet_t meet_status;
	logic signed [17:0] point_one_x, point_one_y, point_two_x, point_two_y;

	meet_res_t expected_meets[$];
	logic [15:0] tol_model;
	bit row_typed;
	meet_res_t row_res;
	int errors;
	int n_sent, n_checked, n_tangent, n_two;

	circle_pair_intersection #(.FRACTION_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_center_x(first_center_x), .first_center_y(first_center_y),
		.first_radius(first_radius),
		.second_center_x(second_center_x), .second_center_y(second_center_y),
		.second_radius(second_radius),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .meet_status(meet_status),
		.point_one_x(point_one_x), .point_one_y(point_one_y),
		.point_two_x(point_two_x), .point_two_y(point_two_y)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [63:0] isqrt(logic [127:0] a);
		logic [129:0] rem;
		logic [129:0] trial;
		logic [63:0] root;
		rem = '0;
		root = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | ((a >> (2 * i)) & 128'd3);
			trial = ({66'd0, root} << 2) | 130'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic logic signed [17:0] div_sat(logic signed [127:0] num,
			logic signed [127:0] den);
		logic signed [127:0] q;
		q = num / den;
		if (q > 131071) q = 131071;
		if (q < -131072) q = -131072;
		return q[17:0];
	endfunction

	function automatic meet_res_t predict_meet(longint x1, longint y1, longint r1,
			longint x2, longint y2, longint r2, logic [15:0] tol);
		meet_res_t res;
		longint dx, dy, sum, dif, bigd, d_f, tol_f, e1, e2, n, tx, ty;
		logic [127:0] f1, f2, s_f;
		logic signed [127:0] den, bx, by, ox, oy;
		dx = x2 - x1;
		dy = y2 - y1;
		sum = r1 + r2;
		dif = r1 > r2 ? r1 - r2 : r2 - r1;
		bigd = dx * dx + dy * dy;
		d_f = longint'(isqrt(128'(bigd) << (2 * FB)));
		tol_f = longint'(tol) << (FB - 8);
		e1 = d_f - (sum << FB);
		e2 = d_f - (dif << FB);
		if (e1 < 0) e1 = -e1;
		if (e2 < 0) e2 = -e2;
		res = '{MEET_NONE, 18'sd0, 18'sd0, 18'sd0, 18'sd0};
		if (e1 < tol_f || e2 < tol_f) begin
			res.st = MEET_TANGENT;
			if (sum == 0) begin
				res.p1x = x1[17:0];
				res.p1y = y1[17:0];
			end else begin
				res.p1x = 18'((x1 * r2 + x2 * r1) / sum);
				res.p1y = 18'((y1 * r2 + y2 * r1) / sum);
			end
		end else if (d_f < (sum << FB) && bigd != 0 && bigd >= dif * dif) begin
			n = r1 * r1 - r2 * r2 + bigd;
			f1 = 128'(sum * sum - bigd);
			f2 = 128'(bigd - dif * dif);
			s_f = 128'(isqrt((f1 * f2) << (2 * FB)));
			den = 128'(2 * bigd) << FB;
			tx = 2 * bigd * x1 + n * dx;
			ty = 2 * bigd * y1 + n * dy;
			bx = 128'(tx) <<< FB;
			by = 128'(ty) <<< FB;
			ox = 128'(dy) * $signed(s_f);
			oy = 128'(dx) * $signed(s_f);
			res.st = MEET_TWO;
			res.p1x = div_sat(bx + ox, den);
			res.p1y = div_sat(by - oy, den);
			res.p2x = div_sat(bx - ox, den);
			res.p2y = div_sat(by + oy, den);
		end
		return res;
	endfunction

	// acceptance, register tracking and result checking
	always @(posedge clk) begin
		meet_res_t e, got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) tol_model = cfg_data;
			if (start && !busy) begin
				if (row_typed) e = row_res;
				else e = predict_meet(first_center_x, first_center_y, first_radius,
						second_center_x, second_center_y, second_radius, tol_model);
				expected_meets.push_back(e);
				n_sent++;
			end
			if (done) begin
				got = '{meet_status, point_one_x, point_one_y, point_two_x, point_two_y};
				if (expected_meets.size() == 0) begin
					$error("result transaction with nothing expected");
					errors++;
				end else begin
					e = expected_meets.pop_front();
					n_checked++;
					if (e.st == MEET_TANGENT) n_tangent++;
					if (e.st == MEET_TWO) n_two++;
					if (got.st !== e.st) begin
						$error("meet_status exp %0d got %0d", e.st, got.st);
						errors++;
					end
					if (got.p1x !== e.p1x) begin
						$error("point_one_x exp %0d got %0d", e.p1x, got.p1x);
						errors++;
					end
					if (got.p1y !== e.p1y) begin
						$error("point_one_y exp %0d got %0d", e.p1y, got.p1y);
						errors++;
					end
					if (got.p2x !== e.p2x) begin
						$error("point_two_x exp %0d got %0d", e.p2x, got.p2x);
						errors++;
					end
					if (got.p2y !== e.p2y) begin
						$error("point_two_y exp %0d got %0d", e.p2y, got.p2y);
						errors++;
					end
				end
			end
		end
	end

	task automatic drive_pair(int x1, int y1, int r1, int x2, int y2, int r2, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		first_center_x <= 16'(x1);
		first_center_y <= 16'(y1);
		first_radius <= 15'(r1);
		second_center_x <= 16'(x2);
		second_center_y <= 16'(y2);
		second_radius <= 15'(r2);
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic int clip(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic random_pair(int idle_pct);
		int x1, y1, x2, y2, r1, r2, di, kind;
		real d;
		kind = $urandom_range(99);
		if (kind < 20) begin
			drive_pair($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
				$urandom_range(32767), $urandom_range(65535) - 32768,
				$urandom_range(65535) - 32768, $urandom_range(32767), idle_pct);
		end else if (kind < 30) begin
			drive_pair($urandom_range(16) - 8, $urandom_range(16) - 8, $urandom_range(8),
				$urandom_range(16) - 8, $urandom_range(16) - 8, $urandom_range(8),
				idle_pct);
		end else begin
			x1 = $urandom_range(65535) - 32768;
			y1 = $urandom_range(65535) - 32768;
			x2 = clip(x1 + $urandom_range(6000) - 3000, -32768, 32767);
			y2 = clip(y1 + $urandom_range(6000) - 3000, -32768, 32767);
			d = $sqrt(real'((x2 - x1) * (x2 - x1) + (y2 - y1) * (y2 - y1)));
			di = int'(d);
			r1 = $urandom_range(4000);
			if (kind < 75) begin
				r2 = (di > r1 ? di - r1 : r1 - di) + $urandom_range(2 * r1);
			end else if ($urandom_range(1)) begin
				r2 = di - r1 + $urandom_range(2) - 1;
			end else begin
				r2 = r1 + ($urandom_range(1) ? di : -di) + $urandom_range(2) - 1;
			end
			drive_pair(x1, y1, r1, x2, y2, clip(r2, 0, 32767), idle_pct);
		end
	endtask

	task automatic write_tolerance(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_meets.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	pair_row_t pair_rows[] = '{
		'{-32768, -32768, 0, -32768, -32768, 0, 1, MEET_TANGENT, -32768, -32768},
		'{0, 0, 5, 0, 0, 10, 1, MEET_NONE, 0, 0},
		'{-32768, -32768, 0, 32767, 32767, 0, 1, MEET_NONE, 0, 0},
		'{0, 0, 100, 1, 1, 2, 1, MEET_NONE, 0, 0},
		'{32767, 32767, 32767, 32767, 32767, 0, 1, MEET_NONE, 0, 0},
		'{-32768, -32768, 32767, 32767, 32767, 32767, 0, MEET_NONE, 0, 0},
		'{32767, -32768, 32767, -32768, 32767, 32767, 0, MEET_NONE, 0, 0},
		'{0, 0, 5, 6, 0, 5, 0, MEET_NONE, 0, 0},
		'{0, 0, 3, 10, 0, 7, 0, MEET_NONE, 0, 0},
		'{0, 0, 10, 4, 0, 6, 0, MEET_NONE, 0, 0},
		'{-100, 50, 32767, 100, -50, 1, 0, MEET_NONE, 0, 0},
		'{32767, 32767, 1, 32766, 32767, 1, 0, MEET_NONE, 0, 0}
	};

	logic [15:0] tol_phases[5];
	int idle_phases[4] = '{0, 53, 0, 38};

	initial begin
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		first_center_x = '0;
		first_center_y = '0;
		first_radius = '0;
		second_center_x = '0;
		second_center_y = '0;
		second_radius = '0;
		row_typed = 1'b0;
		row_res = '{MEET_NONE, 18'sd0, 18'sd0, 18'sd0, 18'sd0};
		tol_model = TOL_RESET;
		errors = 0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (pair_rows[i]) begin
			row_typed <= pair_rows[i].typed;
			row_res <= '{pair_rows[i].st, 18'(pair_rows[i].p1x), 18'(pair_rows[i].p1y),
				18'sd0, 18'sd0};
			drive_pair(pair_rows[i].x1, pair_rows[i].y1, pair_rows[i].r1,
				pair_rows[i].x2, pair_rows[i].y2, pair_rows[i].r2, 0);
		end
		row_typed <= 1'b0;
		start <= 1'b0;
		drain();

		tol_phases = '{16'd0, 16'd65535, 16'd1, 16'($urandom_range(65535)), TOL_RESET};
		for (int p = 0; p < 5; p++) begin
			write_tolerance(tol_phases[p]);
			for (int k = 0; k < 400; k++) random_pair(idle_phases[(k / 100) % 4]);
			start <= 1'b0;
			drain();
		end

		$display("%0d circle pairs sent, %0d results checked (%0d tangent, %0d two-point)",
			n_sent, n_checked, n_tangent, n_two);
		$display("tolerances 256, 0, 65535, 1, random; sender idling 0/53/38 percent");
		if (errors == 0 && expected_meets.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
